[design/ccfr_pkg.sv]
// Shared types, constants and CRC-8 step for the COBS/CRC-8 frame receiver.
`timescale 1ns / 1ps

package ccfr_pkg;

    localparam logic [7:0] FRAME_DELIM   = 8'h00;
    localparam logic [7:0] COBS_MAX_CODE = 8'hFF;
    localparam logic [7:0] CRC8_POLY     = 8'h07;
    localparam int unsigned HDR_BYTES    = 3;
    localparam int unsigned OVERHEAD     = 4;

    typedef enum logic [2:0] {
        FS_OK        = 3'd0,
        FS_SHORT     = 3'd1,
        FS_LENGTH    = 3'd2,
        FS_CRC       = 3'd3,
        FS_BAD_COBS  = 3'd4
    } frame_status_t;

    typedef enum logic {
        RK_PAYLOAD = 1'b0,
        RK_STATUS  = 1'b1
    } result_kind_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC8_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/cobs_crc8_frame_receiver_top.sv]
// COBS deframer with CRC-8 check: decodes link bytes into payload bytes and frame status.
//
//   channel | ports                | direction | per transaction
//   --------+----------------------+-----------+-------------------------------------------
//   s_      | s_valid/s_ready      | in        | s_rx_byte: one link byte, 0x00 ends frame
//   m_      | m_valid/m_ready      | out       | kind, payload byte/index, type, length, status
//
// One link byte per clock while s_ready is high; a byte's result, if any, is registered
// on acceptance and held in the output register. s_ready is high while the output
// register is empty or being drained, so bytes stream back to back under m_ready.
// Synchronous active-low reset clears all frame state and the output valid.
`timescale 1ns / 1ps

module cobs_crc8_frame_receiver_top
    import ccfr_pkg::*;
#(
    parameter int MAX_ENCODED_BYTES = 264,
    parameter int MAX_DECODED_BYTES = 260
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_payload_index,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_payload_length,
    output logic [2:0]  m_frame_status
);

    localparam int ENC_W = $clog2(MAX_ENCODED_BYTES + 1);
    localparam int DEC_W = $clog2(MAX_DECODED_BYTES + 1);
    localparam logic [ENC_W-1:0] ENC_MAX = ENC_W'(MAX_ENCODED_BYTES);
    localparam logic [DEC_W-1:0] DEC_MAX = DEC_W'(MAX_DECODED_BYTES);
    localparam logic [DEC_W-1:0] DEC_HDR = DEC_W'(HDR_BYTES);

    logic [ENC_W-1:0] enc_count_reg, enc_count_next;
    logic [7:0]       grp_rem_reg, grp_rem_next;
    logic             zero_pend_reg, zero_pend_next;
    logic [DEC_W-1:0] dec_count_reg, dec_count_next;
    logic [7:0]       type_reg, type_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       check_reg, check_next;
    logic             crc_seen_reg, crc_seen_next;
    logic             ovf_reg, ovf_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [7:0]       out_index_reg, out_index_next;
    logic [7:0]       out_type_reg, out_type_next;
    logic [15:0]      out_len_reg, out_len_next;
    logic [2:0]       out_status_reg, out_status_next;

    logic             accept;
    logic             dec_en;
    logic [7:0]       dec_val;
    logic [DEC_W-1:0] pos;
    frame_status_t    status;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign pos     = dec_count_reg - DEC_HDR;

    always_comb begin
        if (ovf_reg) begin
            status = FS_LENGTH;
        end else if (grp_rem_reg != 8'd0) begin
            status = FS_BAD_COBS;
        end else if (dec_count_reg < DEC_W'(OVERHEAD)) begin
            status = FS_SHORT;
        end else if ((17'(dec_count_reg) != 17'(len_reg) + 17'(OVERHEAD)) || !crc_seen_reg) begin
            status = FS_LENGTH;
        end else if (crc_reg != check_reg) begin
            status = FS_CRC;
        end else begin
            status = FS_OK;
        end
    end

    always_comb begin
        enc_count_next  = enc_count_reg;
        grp_rem_next    = grp_rem_reg;
        zero_pend_next  = zero_pend_reg;
        dec_count_next  = dec_count_reg;
        type_next       = type_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        check_next      = check_reg;
        crc_seen_next   = crc_seen_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_index_next  = out_index_reg;
        out_type_next   = out_type_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        dec_en          = 1'b0;
        dec_val         = s_rx_byte;

        if (accept) begin
            if (s_rx_byte == FRAME_DELIM) begin
                if (enc_count_reg != '0 || ovf_reg) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = RK_STATUS;
                    out_byte_next   = 8'd0;
                    out_index_next  = 8'd0;
                    out_type_next   = type_reg;
                    out_len_next    = len_reg;
                    out_status_next = status;
                end
                enc_count_next = '0;
                grp_rem_next   = 8'd0;
                zero_pend_next = 1'b0;
                dec_count_next = '0;
                type_next      = 8'd0;
                len_next       = 16'd0;
                crc_next       = 8'd0;
                check_next     = 8'd0;
                crc_seen_next  = 1'b0;
                ovf_next       = 1'b0;
            end else if (enc_count_reg >= ENC_MAX) begin
                ovf_next = 1'b1;
            end else begin
                enc_count_next = enc_count_reg + 1'b1;
                if (grp_rem_reg == 8'd0) begin
                    grp_rem_next   = s_rx_byte - 8'd1;
                    zero_pend_next = (s_rx_byte != COBS_MAX_CODE);
                    dec_en         = zero_pend_reg;
                    dec_val        = 8'd0;
                end else begin
                    grp_rem_next = grp_rem_reg - 8'd1;
                    dec_en       = 1'b1;
                end
            end
        end

        if (dec_en) begin
            if (dec_count_reg >= DEC_MAX) begin
                ovf_next = 1'b1;
            end else begin
                dec_count_next = dec_count_reg + 1'b1;
                if (dec_count_reg == DEC_W'(0)) begin
                    type_next = dec_val;
                    crc_next  = crc8_update(crc_reg, dec_val);
                end else if (dec_count_reg == DEC_W'(1)) begin
                    len_next  = {len_reg[15:8], dec_val};
                    crc_next  = crc8_update(crc_reg, dec_val);
                end else if (dec_count_reg == DEC_W'(2)) begin
                    len_next  = {dec_val, len_reg[7:0]};
                    crc_next  = crc8_update(crc_reg, dec_val);
                end else if (16'(pos) < len_reg) begin
                    crc_next        = crc8_update(crc_reg, dec_val);
                    out_valid_next  = 1'b1;
                    out_kind_next   = RK_PAYLOAD;
                    out_byte_next   = dec_val;
                    out_index_next  = pos[7:0];
                    out_type_next   = type_reg;
                    out_len_next    = len_reg;
                    out_status_next = FS_OK;
                end else if (16'(pos) == len_reg) begin
                    check_next    = dec_val;
                    crc_seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_count_reg <= '0;
            grp_rem_reg   <= 8'd0;
            zero_pend_reg <= 1'b0;
            dec_count_reg <= '0;
            type_reg      <= 8'd0;
            len_reg       <= 16'd0;
            crc_reg       <= 8'd0;
            check_reg     <= 8'd0;
            crc_seen_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            enc_count_reg <= enc_count_next;
            grp_rem_reg   <= grp_rem_next;
            zero_pend_reg <= zero_pend_next;
            dec_count_reg <= dec_count_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            check_reg     <= check_next;
            crc_seen_reg  <= crc_seen_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_index_reg  <= out_index_next;
        out_type_reg   <= out_type_next;
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = out_kind_reg;
    assign m_payload_byte   = out_byte_reg;
    assign m_payload_index  = out_index_reg;
    assign m_frame_type     = out_type_reg;
    assign m_payload_length = out_len_reg;
    assign m_frame_status   = out_status_reg;

endmodule

[tb/sv/tb_cobs_crc8_frame_receiver_top.sv]
// Self-checking testbench for the COBS/CRC-8 frame receiver top level.
`timescale 1ns / 1ps

module tb_cobs_crc8_frame_receiver_top;
    import ccfr_pkg::*;

    localparam int MAX_ENC = 264;
    localparam int MAX_DEC = 260;
    localparam int PHASE_BYTES = 90;

    typedef struct packed {
        result_kind_t  kind;
        logic [7:0]    data;
        logic [7:0]    pidx;
        logic [7:0]    ftype;
        logic [15:0]   length;
        frame_status_t status;
    } rx_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_result_kind;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_payload_index;
    logic [7:0]  m_frame_type;
    logic [15:0] m_payload_length;
    logic [2:0]  m_frame_status;

    cobs_crc8_frame_receiver_top #(
        .MAX_ENCODED_BYTES(MAX_ENC),
        .MAX_DECODED_BYTES(MAX_DEC)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_frame_type    (m_frame_type),
        .m_payload_length(m_payload_length),
        .m_frame_status  (m_frame_status)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    logic [7:0] link_q[$];
    logic [7:0] frame_buf[$];
    logic [7:0] grp_buf[$];
    rx_result_t expected_q[$];
    int         queued_total = 0;
    int         accepted_total = 0;
    int         payload_checked = 0;
    int         status_hits[5] = '{default: 0};
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       in_taken = 1'b0;

    // deframer state
    logic [8:0]  enc_cnt = '0;
    logic [7:0]  grp_left = '0;
    logic        zero_due = 1'b0;
    logic [8:0]  dec_cnt = '0;
    logic [7:0]  cur_type = '0;
    logic [15:0] cur_len = '0;
    logic [7:0]  crc_acc = '0;
    logic [7:0]  crc_rx = '0;
    logic        crc_hit = 1'b0;
    logic        ovf = 1'b0;

    // bit-serial, MSB first
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            r = {r[6:0], 1'b0} ^ (((r[7] ^ b[k]) != 1'b0) ? CRC8_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic clear_deframer();
        enc_cnt  = '0;
        grp_left = '0;
        zero_due = 1'b0;
        dec_cnt  = '0;
        cur_type = '0;
        cur_len  = '0;
        crc_acc  = '0;
        crc_rx   = '0;
        crc_hit  = 1'b0;
        ovf      = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b, output bit emit, output rx_result_t r);
        int d;
        int p;
        emit = 1'b0;
        r = '0;
        if (int'(dec_cnt) >= MAX_DEC) begin
            ovf = 1'b1;
        end else begin
            d = int'(dec_cnt);
            dec_cnt = dec_cnt + 9'd1;
            if (d < HDR_BYTES) begin
                if (d == 0) cur_type = b;
                else if (d == 1) cur_len[7:0] = b;
                else cur_len[15:8] = b;
                crc_acc = crc8_next(crc_acc, b);
            end else begin
                p = d - HDR_BYTES;
                if (p < int'(cur_len)) begin
                    crc_acc  = crc8_next(crc_acc, b);
                    emit     = 1'b1;
                    r.kind   = RK_PAYLOAD;
                    r.data   = b;
                    r.pidx   = p[7:0];
                    r.ftype  = cur_type;
                    r.length = cur_len;
                    r.status = FS_OK;
                end else if (p == int'(cur_len)) begin
                    crc_rx  = b;
                    crc_hit = 1'b1;
                end
            end
        end
    endtask

    task automatic predict_link_byte(input logic [7:0] b, output bit emit, output rx_result_t r);
        frame_status_t st;
        bit had_zero;
        emit = 1'b0;
        r = '0;
        if (b == FRAME_DELIM) begin
            if (enc_cnt != 0 || ovf) begin
                if (ovf) st = FS_LENGTH;
                else if (grp_left != 0) st = FS_BAD_COBS;
                else if (int'(dec_cnt) < OVERHEAD) st = FS_SHORT;
                else if (int'(dec_cnt) != int'(cur_len) + OVERHEAD || !crc_hit) st = FS_LENGTH;
                else if (crc_acc != crc_rx) st = FS_CRC;
                else st = FS_OK;
                emit     = 1'b1;
                r.kind   = RK_STATUS;
                r.ftype  = cur_type;
                r.length = cur_len;
                r.status = st;
            end
            clear_deframer();
        end else if (int'(enc_cnt) >= MAX_ENC) begin
            ovf = 1'b1;
        end else begin
            enc_cnt = enc_cnt + 9'd1;
            if (grp_left == 0) begin
                had_zero = zero_due;
                grp_left = b - 8'd1;
                zero_due = (b != COBS_MAX_CODE);
                if (had_zero) decode_byte(8'h00, emit, r);
            end else begin
                grp_left = grp_left - 8'd1;
                decode_byte(b, emit, r);
            end
        end
    endtask

    // stimulus construction
    task automatic queue_link_byte(input logic [7:0] b);
        link_q.push_back(b);
        queued_total++;
    endtask

    task automatic flush_group();
        queue_link_byte(8'(grp_buf.size() + 1));
        foreach (grp_buf[j]) queue_link_byte(grp_buf[j]);
        grp_buf = {};
    endtask

    task automatic push_cobs();
        grp_buf = {};
        foreach (frame_buf[i]) begin
            if (frame_buf[i] == FRAME_DELIM) begin
                flush_group();
            end else begin
                grp_buf.push_back(frame_buf[i]);
                if (grp_buf.size() == int'(COBS_MAX_CODE) - 1) flush_group();
            end
        end
        flush_group();
    endtask

    task automatic start_frame(input logic [7:0] ftype, input logic [15:0] lfield);
        frame_buf = {};
        frame_buf.push_back(ftype);
        frame_buf.push_back(lfield[7:0]);
        frame_buf.push_back(lfield[15:8]);
    endtask

    task automatic finish_frame(input logic [7:0] crc_flip, input logic [7:0] tail_code);
        logic [7:0] c;
        c = 8'h00;
        foreach (frame_buf[i]) c = crc8_next(c, frame_buf[i]);
        frame_buf.push_back(c ^ crc_flip);
        push_cobs();
        if (tail_code != 8'h00) queue_link_byte(tail_code);
        queue_link_byte(FRAME_DELIM);
    endtask

    function automatic logic [7:0] rand_data_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) return 8'h00;
        if (roll < 35) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic gen_random_frame();
        int roll;
        int plen;
        logic [15:0] lfield;
        roll = $urandom_range(99);
        plen = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
        if (roll < 5) begin
            queue_link_byte(FRAME_DELIM);
        end else if (roll < 15) begin
            repeat ($urandom_range(12, 1)) begin
                queue_link_byte(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));
            end
            queue_link_byte(FRAME_DELIM);
        end else if (roll < 22) begin
            frame_buf = {};
            repeat ($urandom_range(3, 1)) frame_buf.push_back(rand_data_byte());
            push_cobs();
            queue_link_byte(FRAME_DELIM);
        end else begin
            lfield = 16'(plen);
            if (roll < 32) begin
                if ($urandom_range(1) == 0) lfield = 16'($urandom_range(65535));
                else if ($urandom_range(1) == 0) lfield = lfield + 16'($urandom_range(3, 1));
                else lfield = lfield - 16'($urandom_range(3, 1));
                if (lfield == 16'(plen)) lfield = lfield + 16'd1;
            end
            start_frame(rand_data_byte(), lfield);
            repeat (plen) frame_buf.push_back(rand_data_byte());
            finish_frame((roll >= 32 && roll < 42) ? 8'($urandom_range(255, 1)) : 8'h00,
                         (roll >= 42 && roll < 50) ? 8'($urandom_range(255, 2)) : 8'h00);
        end
    endtask

    // long frames: largest that fits, decoded overflow, encoded overflow
    task automatic gen_big_frame(input int sel);
        if (sel < 2) begin
            start_frame(8'($urandom_range(255, 1)), (sel == 0) ? 16'd256 : 16'd257);
            repeat ((sel == 0) ? 256 : 257) frame_buf.push_back(8'($urandom_range(255, 1)));
            finish_frame(8'h00, 8'h00);
        end else begin
            queue_link_byte(COBS_MAX_CODE);
            repeat (MAX_ENC + 5) queue_link_byte(8'($urandom_range(255, 1)));
            queue_link_byte(FRAME_DELIM);
        end
    endtask

    task automatic wait_drain();
        while (accepted_total != queued_total || expected_q.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    // driver
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (link_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid   <= 1'b1;
                s_rx_byte <= link_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin : monitor
        rx_result_t seen;
        rx_result_t want;
        rx_result_t pred;
        bit         got;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.kind   = result_kind_t'(m_result_kind);
                seen.data   = m_payload_byte;
                seen.pidx   = m_payload_index;
                seen.ftype  = m_frame_type;
                seen.length = m_payload_length;
                seen.status = frame_status_t'(m_frame_status);
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transaction kind %0d status %0d",
                             $time, seen.kind, seen.status);
                end else begin
                    want = expected_q.pop_front();
                    if (want.kind == RK_STATUS) status_hits[int'(want.status)]++;
                    else payload_checked++;
                    if (seen != want) begin
                        errors++;
                        $display("%0t: mismatch expected kind %0d byte %02h idx %0d type %02h ",
                                 $time, want.kind, want.data, want.pidx, want.ftype,
                                 "len %04h status %0d, actual kind %0d byte %02h idx %0d ",
                                 want.length, want.status, seen.kind, seen.data, seen.pidx,
                                 "type %02h len %04h status %0d",
                                 seen.ftype, seen.length, seen.status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                accepted_total++;
                predict_link_byte(s_rx_byte, got, pred);
                if (got) expected_q.push_back(pred);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int start_count;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty, short, truncated group, ok, bad crc, length mismatch
        queue_link_byte(FRAME_DELIM);
        queue_link_byte(8'h02);
        queue_link_byte(8'hAA);
        queue_link_byte(FRAME_DELIM);
        queue_link_byte(8'h03);
        queue_link_byte(8'h11);
        queue_link_byte(FRAME_DELIM);
        start_frame(8'hFF, 16'd1);
        frame_buf.push_back(8'h00);
        finish_frame(8'h00, 8'h00);
        start_frame(8'h00, 16'd0);
        finish_frame(8'h5A, 8'h00);
        start_frame(8'h00, 16'hFFFF);
        finish_frame(8'h00, 8'h00);
        wait_drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (ph != 1) gen_big_frame((ph == 0) ? 0 : ph - 1);
            start_count = queued_total;
            while (queued_total - start_count < PHASE_BYTES) gen_random_frame();
            wait_drain();
        end

        $display("run covered %0d link bytes in four idle/stall phases, %0d payload bytes checked",
                 accepted_total, payload_checked);
        $display("frame ends: ok %0d, short %0d, length %0d, crc %0d, cobs %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[cobs_crc8_frame_receiver_top.f]
design/ccfr_pkg.sv
design/cobs_crc8_frame_receiver_top.sv
tb/sv/tb_cobs_crc8_frame_receiver_top.sv
